>>> hdl/cfr_pkg.sv
// Package for the clock frame replacement block: transaction structs, action and
// status codes, and the command and status structs between controller and datapath.
// No dependencies.
package cfr_pkg;

	localparam int FRAME_SLOTS_DEF = 64;
	localparam int PAGE_BITS_DEF   = 20;

	localparam int POOL_W    = 7;
	localparam int SLOT_IN_W = 6;
	localparam int PAGE_IN_W = 20;

	localparam logic [POOL_W-1:0] POOL_RESET = 7'd64;

	localparam logic [2:0] ACT_ALLOC  = 3'd0;
	localparam logic [2:0] ACT_FREE   = 3'd1;
	localparam logic [2:0] ACT_REMOVE = 3'd2;
	localparam logic [2:0] ACT_PIN    = 3'd3;
	localparam logic [2:0] ACT_UNPIN  = 3'd4;
	localparam logic [2:0] ACT_TOUCH  = 3'd5;

	localparam logic [1:0] STAT_OK         = 2'd0;
	localparam logic [1:0] STAT_NO_FRAME   = 2'd1;
	localparam logic [1:0] STAT_ALL_PINNED = 2'd2;

	typedef struct packed {
		logic [2:0]           action;
		logic [SLOT_IN_W-1:0] frame_slot;
		logic [PAGE_IN_W-1:0] map_page;
		logic                 is_write;
	} cfr_req_t;

	typedef struct packed {
		logic [1:0]           status;
		logic [SLOT_IN_W-1:0] granted_slot;
		logic                 evicted;
		logic [PAGE_IN_W-1:0] evicted_page;
		logic                 evicted_dirty;
	} cfr_rsp_t;

	typedef struct packed {
		logic latch;
		logic simple;
		logic scan_step;
		logic take_free;
		logic pin_err;
		logic sweep_init;
		logic sweep_step;
		logic victim_sel;
		logic install_victim;
	} cfr_cmd_t;

	typedef struct packed {
		logic is_alloc;
		logic idx_free;
		logic idx_last;
		logic any_unpinned;
		logic victim_hit;
	} cfr_stat_t;

endpackage

>>> hdl/cfr_datapath.sv
// Datapath of the clock frame replacement block: slot flag vectors, page number
// memory, clock hand, scan counter and result register.
// Depends on cfr_pkg.
module cfr_datapath
	import cfr_pkg::*;
#(
	parameter int FRAME_SLOTS      = FRAME_SLOTS_DEF,
	parameter int PAGE_NUMBER_BITS = PAGE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfr_req_t          req,
	input  logic              cfg_we,
	input  logic [POOL_W-1:0] cfg_wdata,
	input  cfr_cmd_t          cmd,
	output cfr_stat_t         stat,
	output cfr_rsp_t          rsp
);

	localparam int SLOT_W = $clog2(FRAME_SLOTS);
	localparam int CNT_W  = ($clog2(FRAME_SLOTS + 1) > POOL_W) ?
	                        $clog2(FRAME_SLOTS + 1) : POOL_W;
	localparam int EXT_W  = (PAGE_NUMBER_BITS > PAGE_IN_W) ? PAGE_NUMBER_BITS : PAGE_IN_W;
	localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(FRAME_SLOTS);

	logic [POOL_W-1:0]           pool_q;
	logic [FRAME_SLOTS-1:0]      valid_q;
	logic [FRAME_SLOTS-1:0]      pinned_q;
	logic [FRAME_SLOTS-1:0]      acc_q;
	logic [FRAME_SLOTS-1:0]      dirty_q;
	logic [SLOT_W-1:0]           hand_q;
	logic [SLOT_W-1:0]           idx_q;
	logic                        unp_q;
	cfr_req_t                    req_q;
	logic [SLOT_W-1:0]           victim_q;
	logic                        vic_dirty_q;
	logic [PAGE_NUMBER_BITS-1:0] rd_q;
	cfr_rsp_t                    rsp_q;
	logic [PAGE_NUMBER_BITS-1:0] owner_mem [FRAME_SLOTS];

	logic [CNT_W-1:0]            pool_raw;
	logic [CNT_W-1:0]            pool_eff;
	logic [CNT_W-1:0]            slot_ext;
	logic [SLOT_W-1:0]           slot_idx;
	logic                        slot_hit;
	logic [CNT_W-1:0]            idx_ext;
	logic [CNT_W-1:0]            hand_ext;
	logic [CNT_W-1:0]            victim_ext;
	logic [SLOT_W-1:0]           hand_start;
	logic [SLOT_W-1:0]           hand_next;
	logic                        install_en;
	logic [SLOT_W-1:0]           install_idx;
	logic [EXT_W-1:0]            page_in_ext;
	logic [EXT_W-1:0]            rd_ext;
	logic [PAGE_NUMBER_BITS-1:0] wr_page;
	logic                        rsp_en;
	cfr_rsp_t                    rsp_nxt;

	always_comb begin
		pool_raw = CNT_W'(pool_q);
		if (pool_raw == '0) begin
			pool_eff = CNT_W'(1);
		end else if (pool_raw > SLOTS_C) begin
			pool_eff = SLOTS_C;
		end else begin
			pool_eff = pool_raw;
		end
	end

	assign slot_ext   = CNT_W'(req.frame_slot);
	assign slot_idx   = slot_ext[SLOT_W-1:0];
	assign slot_hit   = (slot_ext < SLOTS_C) && valid_q[slot_idx];
	assign idx_ext    = CNT_W'(idx_q);
	assign hand_ext   = CNT_W'(hand_q);
	assign victim_ext = CNT_W'(victim_q);
	assign hand_start = (hand_ext >= pool_eff) ? '0 : hand_q;
	assign hand_next  = ((hand_ext + CNT_W'(1)) >= pool_eff) ? '0 : hand_q + SLOT_W'(1);

	assign stat.is_alloc     = (req.action == ACT_ALLOC);
	assign stat.idx_free     = !valid_q[idx_q];
	assign stat.idx_last     = ((idx_ext + CNT_W'(1)) == pool_eff);
	assign stat.any_unpinned = unp_q | !pinned_q[idx_q];
	assign stat.victim_hit   = !pinned_q[hand_q] && !acc_q[hand_q];

	assign install_en  = cmd.take_free | cmd.install_victim;
	assign install_idx = cmd.take_free ? idx_q : victim_q;
	assign page_in_ext = EXT_W'(req_q.map_page);
	assign wr_page     = page_in_ext[PAGE_NUMBER_BITS-1:0];
	assign rd_ext      = EXT_W'(rd_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q   <= POOL_RESET;
			valid_q  <= '0;
			pinned_q <= '0;
			acc_q    <= '0;
			dirty_q  <= '0;
			hand_q   <= '0;
			idx_q    <= '0;
			unp_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				pool_q <= cfg_wdata;
			end
			if (cmd.latch) begin
				idx_q <= '0;
				unp_q <= 1'b0;
			end
			if (cmd.simple && slot_hit) begin
				unique case (req.action)
					ACT_FREE, ACT_REMOVE: begin
						valid_q[slot_idx]  <= 1'b0;
						pinned_q[slot_idx] <= 1'b0;
						acc_q[slot_idx]    <= 1'b0;
						dirty_q[slot_idx]  <= 1'b0;
					end
					ACT_PIN: begin
						pinned_q[slot_idx] <= 1'b1;
					end
					ACT_UNPIN: begin
						pinned_q[slot_idx] <= 1'b0;
					end
					ACT_TOUCH: begin
						acc_q[slot_idx] <= 1'b1;
						if (req.is_write) begin
							dirty_q[slot_idx] <= 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.scan_step) begin
				idx_q <= idx_q + SLOT_W'(1);
				unp_q <= stat.any_unpinned;
			end
			if (cmd.sweep_init) begin
				hand_q <= hand_start;
			end
			if (cmd.sweep_step) begin
				if (!pinned_q[hand_q]) begin
					acc_q[hand_q] <= 1'b0;
				end
				hand_q <= hand_next;
			end
			if (cmd.victim_sel) begin
				hand_q <= hand_next;
			end
			if (install_en) begin
				valid_q[install_idx]  <= 1'b1;
				pinned_q[install_idx] <= 1'b1;
				acc_q[install_idx]    <= 1'b0;
				dirty_q[install_idx]  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (install_en) begin
			owner_mem[install_idx] <= wr_page;
		end
		if (cmd.victim_sel) begin
			rd_q <= owner_mem[hand_q];
		end
	end

	always_comb begin
		rsp_nxt = '0;
		if (cmd.simple) begin
			rsp_nxt.granted_slot = req.frame_slot;
			if (req.action != ACT_ALLOC && req.action <= ACT_TOUCH && !slot_hit) begin
				rsp_nxt.status = STAT_NO_FRAME;
			end else begin
				rsp_nxt.status = STAT_OK;
			end
		end else if (cmd.take_free) begin
			rsp_nxt.status       = STAT_OK;
			rsp_nxt.granted_slot = idx_ext[SLOT_IN_W-1:0];
		end else if (cmd.pin_err) begin
			rsp_nxt.status = STAT_ALL_PINNED;
		end else if (cmd.install_victim) begin
			rsp_nxt.status        = STAT_OK;
			rsp_nxt.granted_slot  = victim_ext[SLOT_IN_W-1:0];
			rsp_nxt.evicted       = 1'b1;
			rsp_nxt.evicted_page  = rd_ext[PAGE_IN_W-1:0];
			rsp_nxt.evicted_dirty = vic_dirty_q;
		end
	end

	assign rsp_en = cmd.simple | cmd.take_free | cmd.pin_err | cmd.install_victim;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q <= req;
		end
		if (cmd.victim_sel) begin
			victim_q    <= hand_q;
			vic_dirty_q <= dirty_q[hand_q];
		end
		if (rsp_en) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp = rsp_q;

endmodule

>>> hdl/cfr_ctrl.sv
// Controller of the clock frame replacement block: one-hot state machine that
// drives the datapath through a free-slot scan, a clock sweep and an eviction.
// Depends on cfr_pkg.
module cfr_ctrl
	import cfr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  cfr_stat_t stat,
	output cfr_cmd_t  cmd,
	output logic      busy,
	output logic      done
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_SWEEP = 5'b00100,
		S_EVICT = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					if (stat.is_alloc) begin
						state_nxt = S_SCAN;
					end else begin
						cmd.simple = 1'b1;
						state_nxt  = S_DONE;
					end
				end
			end
			S_SCAN: begin
				priority if (stat.idx_free) begin
					cmd.take_free = 1'b1;
					state_nxt     = S_DONE;
				end else if (stat.idx_last) begin
					if (stat.any_unpinned) begin
						cmd.sweep_init = 1'b1;
						state_nxt      = S_SWEEP;
					end else begin
						cmd.pin_err = 1'b1;
						state_nxt   = S_DONE;
					end
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_SWEEP: begin
				if (stat.victim_hit) begin
					cmd.victim_sel = 1'b1;
					state_nxt      = S_EVICT;
				end else begin
					cmd.sweep_step = 1'b1;
				end
			end
			S_EVICT: begin
				cmd.install_victim = 1'b1;
				state_nxt          = S_DONE;
			end
			S_DONE: begin
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not make the block busy");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("block became busy without a start");

	a_sweep_exit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.victim_sel |=> (cmd.install_victim && !done))
		else $error("eviction did not follow victim selection");

endmodule

>>> hdl/clock_frame_replacement.sv
// Top level of the clock frame replacement block: frame table with clock
// replacement and pinning. Instantiates cfr_ctrl and cfr_datapath; uses cfr_pkg.
//
// Channel   Ports                    Handshake
// request   start, busy, req         taken at an edge with start high and busy low
// result    done, rsp                done high for one cycle, always taken
// config    cfg_we, cfg_wdata        pool size written at an edge with cfg_we high
//
// From the accepting edge: free, remove, pin, unpin, touch and unknown actions go straight
// to done; alloc scans up from slot 0 and takes the lowest free slot; with no free slot the
// clock sweep visits at most twice the pool and evicts the first slot neither pinned nor
// accessed, and with every slot pinned the result is all pinned. One slot is examined per cycle.
// Reset clears all slot flags, the hand and the controller; pool size resets to 64.
// The receiver cannot stall; a new request is taken in the cycle after done.
module clock_frame_replacement
	import cfr_pkg::*;
#(
	parameter int FRAME_SLOTS      = FRAME_SLOTS_DEF,
	parameter int PAGE_NUMBER_BITS = PAGE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  cfr_req_t          req,
	output logic              done,
	output cfr_rsp_t          rsp,
	input  logic              cfg_we,
	input  logic [POOL_W-1:0] cfg_wdata
);

	cfr_cmd_t  cmd;
	cfr_stat_t stat;

	cfr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	cfr_datapath #(
		.FRAME_SLOTS      (FRAME_SLOTS),
		.PAGE_NUMBER_BITS (PAGE_NUMBER_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat),
		.rsp       (rsp)
	);

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for clock_frame_replacement: directed and random frame table
// transactions, each result checked against a built-in model of the clock sweep.
// Depends on cfr_pkg and the clock_frame_replacement RTL.
module testbench;
	import cfr_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int SLOTS = FRAME_SLOTS_DEF;
	localparam logic [2:0] ACT_SPARE_6 = 3'd6;
	localparam logic [2:0] ACT_SPARE_7 = 3'd7;
	localparam logic [PAGE_IN_W-1:0] PAGE_MAX = '1;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	cfr_req_t          req;
	logic              done;
	cfr_rsp_t          rsp;
	logic              cfg_we;
	logic [POOL_W-1:0] cfg_wdata;

	logic [SLOTS-1:0]     frame_valid;
	logic [SLOTS-1:0]     frame_pinned;
	logic [SLOTS-1:0]     frame_accessed;
	logic [SLOTS-1:0]     frame_dirty;
	logic [PAGE_IN_W-1:0] frame_page [SLOTS];
	int unsigned          sweep_pos;
	logic [POOL_W-1:0]    pool_setting;

	cfr_rsp_t    pending_results [$];
	int unsigned mismatch_count;
	int unsigned cycle_count;
	int unsigned useful_ops;
	bit          idle_gaps;

	clock_frame_replacement u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned usable_slots();
		if (pool_setting == 0) return 1;
		if (pool_setting > SLOTS) return SLOTS;
		return 32'(pool_setting);
	endfunction

	function automatic void claim_frame(int unsigned s, logic [PAGE_IN_W-1:0] page);
		frame_valid[s] = 1'b1;
		frame_pinned[s] = 1'b1;
		frame_accessed[s] = 1'b0;
		frame_dirty[s] = 1'b0;
		frame_page[s] = page;
	endfunction

	function automatic cfr_rsp_t apply_frame_op(cfr_req_t r);
		cfr_rsp_t    res;
		int unsigned pool;
		int unsigned s;
		int unsigned h;
		int unsigned cur;
		int unsigned victim;
		int unsigned n;
		bit          found;
		bit          any_unpinned;
		res = '0;
		res.status = STAT_OK;
		res.granted_slot = r.frame_slot;
		pool = usable_slots();
		found = 1'b0;
		any_unpinned = 1'b0;
		victim = 0;
		s = 0;
		if (r.action == ACT_ALLOC) begin
			for (int i = 0; i < pool; i++) begin
				if (!found && !frame_valid[i]) begin
					found = 1'b1;
					s = i;
				end
			end
			if (found) begin
				claim_frame(s, r.map_page);
				res.granted_slot = SLOT_IN_W'(s);
			end else begin
				for (int i = 0; i < pool; i++)
					if (!frame_pinned[i]) any_unpinned = 1'b1;
				if (!any_unpinned) begin
					res.status = STAT_ALL_PINNED;
					res.granted_slot = '0;
				end else begin
					h = (sweep_pos >= pool) ? 0 : sweep_pos;
					for (n = 0; n < 2 * pool; n++) begin
						cur = h;
						h = (h + 1 >= pool) ? 0 : h + 1;
						if (frame_pinned[cur]) continue;
						if (frame_accessed[cur]) begin
							frame_accessed[cur] = 1'b0;
							continue;
						end
						victim = cur;
						break;
					end
					sweep_pos = h;
					res.evicted = 1'b1;
					res.evicted_page = frame_page[victim];
					res.evicted_dirty = frame_dirty[victim];
					claim_frame(victim, r.map_page);
					res.granted_slot = SLOT_IN_W'(victim);
				end
			end
		end else if (r.action <= ACT_TOUCH) begin
			if (!frame_valid[r.frame_slot]) begin
				res.status = STAT_NO_FRAME;
			end else begin
				case (r.action)
					ACT_FREE, ACT_REMOVE: begin
						frame_valid[r.frame_slot] = 1'b0;
						frame_pinned[r.frame_slot] = 1'b0;
						frame_accessed[r.frame_slot] = 1'b0;
						frame_dirty[r.frame_slot] = 1'b0;
					end
					ACT_PIN: frame_pinned[r.frame_slot] = 1'b1;
					ACT_UNPIN: frame_pinned[r.frame_slot] = 1'b0;
					default: begin
						frame_accessed[r.frame_slot] = 1'b1;
						if (r.is_write) frame_dirty[r.frame_slot] = 1'b1;
					end
				endcase
			end
		end
		return res;
	endfunction

	function automatic cfr_req_t make_op(logic [2:0] act, logic [SLOT_IN_W-1:0] slot,
			logic [PAGE_IN_W-1:0] page, logic wr);
		cfr_req_t r;
		r.action = act;
		r.frame_slot = slot;
		r.map_page = page;
		r.is_write = wr;
		return r;
	endfunction

	function automatic logic [SLOT_IN_W-1:0] pick_frame_slot();
		int unsigned live [$];
		for (int i = 0; i < SLOTS; i++)
			if (frame_valid[i]) live.push_back(i);
		if (live.size() == 0 || $urandom_range(99) < 15)
			return SLOT_IN_W'($urandom_range(SLOTS - 1));
		return SLOT_IN_W'(live[$urandom_range(live.size() - 1)]);
	endfunction

	function automatic logic [PAGE_IN_W-1:0] random_page();
		int unsigned pick;
		logic [31:0] v;
		pick = $urandom_range(99);
		v = $urandom;
		if (pick < 8) return PAGE_MAX;
		if (pick < 12) return '0;
		return v[PAGE_IN_W-1:0];
	endfunction

	function automatic logic [2:0] random_action();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 35) return ACT_ALLOC;
		if (pick < 38) return ACT_FREE;
		if (pick < 41) return ACT_REMOVE;
		if (pick < 49) return ACT_PIN;
		if (pick < 74) return ACT_UNPIN;
		if (pick < 97) return ACT_TOUCH;
		if (pick < 99) return ACT_SPARE_6;
		return ACT_SPARE_7;
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		if (mismatch_count < 50)
			$display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
		mismatch_count++;
	endtask

	// Called at a rising edge; returns at the edge that accepts the transaction.
	task automatic send_frame_op(cfr_req_t r);
		while (idle_gaps && $urandom_range(99) < 13) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy !== 1'b0);
		pending_results.push_back(apply_frame_op(r));
		if (r.action <= ACT_TOUCH && pending_results[$].status == STAT_OK) useful_ops++;
	endtask

	task automatic set_pool_size(logic [POOL_W-1:0] value);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		pool_setting = value;
	endtask

	task automatic test_basic_actions();
		set_pool_size(POOL_RESET);
		send_frame_op(make_op(ACT_ALLOC, 6'd0, PAGE_MAX, 1'b1));
		send_frame_op(make_op(ACT_ALLOC, 6'd63, '0, 1'b0));
		send_frame_op(make_op(ACT_TOUCH, 6'd0, '0, 1'b1));
		send_frame_op(make_op(ACT_TOUCH, 6'd1, PAGE_MAX, 1'b0));
		send_frame_op(make_op(ACT_PIN, 6'd0, '0, 1'b0));
		send_frame_op(make_op(ACT_UNPIN, 6'd0, '0, 1'b0));
		send_frame_op(make_op(ACT_FREE, 6'd1, '0, 1'b0));
		send_frame_op(make_op(ACT_REMOVE, 6'd0, '0, 1'b0));
		send_frame_op(make_op(ACT_TOUCH, 6'd63, PAGE_MAX, 1'b1));
		send_frame_op(make_op(ACT_PIN, 6'd1, '0, 1'b0));
		send_frame_op(make_op(ACT_SPARE_6, 6'd42, 20'h5A5A5, 1'b0));
		send_frame_op(make_op(ACT_SPARE_7, 6'd63, PAGE_MAX, 1'b1));
	endtask

	task automatic test_pinning_and_eviction();
		set_pool_size(7'd2);
		send_frame_op(make_op(ACT_ALLOC, 6'd0, 20'h12345, 1'b0));
		send_frame_op(make_op(ACT_ALLOC, 6'd0, 20'h54321, 1'b0));
		send_frame_op(make_op(ACT_ALLOC, 6'd0, 20'hABCDE, 1'b0));
		send_frame_op(make_op(ACT_UNPIN, 6'd0, '0, 1'b0));
		send_frame_op(make_op(ACT_UNPIN, 6'd1, '0, 1'b0));
		send_frame_op(make_op(ACT_TOUCH, 6'd0, '0, 1'b1));
		send_frame_op(make_op(ACT_ALLOC, 6'd0, 20'h00001, 1'b0));
		send_frame_op(make_op(ACT_ALLOC, 6'd0, 20'h00002, 1'b0));
	endtask

	task automatic test_pool_limits();
		set_pool_size(7'd0);
		send_frame_op(make_op(ACT_ALLOC, 6'd0, 20'hFEDCB, 1'b0));
		send_frame_op(make_op(ACT_UNPIN, 6'd0, '0, 1'b0));
		send_frame_op(make_op(ACT_ALLOC, 6'd0, 20'h13579, 1'b0));
		send_frame_op(make_op(ACT_TOUCH, 6'd1, '0, 1'b1));
		set_pool_size(7'd127);
		send_frame_op(make_op(ACT_ALLOC, 6'd0, 20'h24680, 1'b0));
	endtask

	task automatic run_random_phase(logic [POOL_W-1:0] pool_value, int unsigned ops,
			bit with_gaps);
		int unsigned goal;
		cfr_req_t r;
		set_pool_size(pool_value);
		idle_gaps = with_gaps;
		goal = useful_ops + ops;
		while (useful_ops < goal) begin
			r.action = random_action();
			r.frame_slot = pick_frame_slot();
			r.map_page = random_page();
			r.is_write = 1'($urandom_range(1));
			send_frame_op(r);
		end
		idle_gaps = 1'b1;
	endtask

	task automatic test_random_traffic();
		run_random_phase(7'd8, 100, 1'b1);
		run_random_phase(7'd64, 150, 1'b1);
		run_random_phase(7'd127, 150, 1'b0);
		run_random_phase(7'd3, 100, 1'b1);
		run_random_phase(7'd1, 80, 1'b1);
		run_random_phase(7'd0, 60, 1'b1);
		run_random_phase(7'd16, 120, 1'b1);
		run_random_phase(7'd40, 120, 1'b1);
		run_random_phase(7'd2, 100, 1'b1);
		run_random_phase(7'd65, 150, 1'b1);
	endtask

	always @(posedge clk) begin : result_check
		cfr_rsp_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected transaction", rsp.granted_slot, 0);
			end else begin
				want = pending_results.pop_front();
				if (rsp.status !== want.status)
					report_mismatch("status", rsp.status, want.status);
				if (rsp.granted_slot !== want.granted_slot)
					report_mismatch("granted_slot", rsp.granted_slot, want.granted_slot);
				if (rsp.evicted !== want.evicted)
					report_mismatch("evicted", rsp.evicted, want.evicted);
				if (rsp.evicted_page !== want.evicted_page)
					report_mismatch("evicted_page", rsp.evicted_page, want.evicted_page);
				if (rsp.evicted_dirty !== want.evicted_dirty)
					report_mismatch("evicted_dirty", rsp.evicted_dirty, want.evicted_dirty);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** clock_frame_replacement: FAILED **");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		frame_valid = '0;
		frame_pinned = '0;
		frame_accessed = '0;
		frame_dirty = '0;
		sweep_pos = 0;
		pool_setting = POOL_RESET;
		mismatch_count = 0;
		cycle_count = 0;
		useful_ops = 0;
		idle_gaps = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_actions();
		test_pinning_and_eviction();
		test_pool_limits();
		test_random_traffic();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("** clock_frame_replacement: PASSED **");
		end else begin
			$display("** clock_frame_replacement: FAILED **");
		end
		$finish;
	end

endmodule
